FILE: rtl/pcm_channel_extract_to_float_top_defines.svh
// Assertion macros shared by the PCM extractor RTL.
`ifndef PCM_CHANNEL_EXTRACT_TO_FLOAT_TOP_DEFINES_SVH
`define PCM_CHANNEL_EXTRACT_TO_FLOAT_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PCX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcx_pkg.sv
// Types and constants for the PCM channel extractor.
package pcx_pkg;

  typedef enum logic [1:0] {
    ENC_FLOAT32 = 2'd0,
    ENC_PCM16   = 2'd1,
    ENC_PCM24   = 2'd2,
    ENC_PCM32   = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCFG  = 2'd1,
    ST_PARTIAL = 2'd2
  } status_t;

  localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [1:0] REG_SELECTED_CHANNEL = 2'd1;
  localparam logic [1:0] REG_SAMPLE_ENCODING  = 2'd2;
  localparam logic [1:0] REG_VALID_BIT_COUNT  = 2'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic [1:0]  status;
    logic        last_sample;
  } out_item_t;

  // Work item handed from the front to the converter
  typedef struct packed {
    logic [31:0] raw;
    logic [1:0]  status;
    logic        last;
    logic        is_float;
    logic [5:0]  cbits;
    logic [5:0]  vbits;
  } job_t;

endpackage

FILE: rtl/pcx_front.sv
// Front end: frame position tracking and byte assembly.
module pcx_front
  import pcx_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  in_item_t   in_item,
  input  logic       take,
  input  logic [5:0] channel_count,
  input  logic [4:0] selected_channel,
  input  logic [1:0] sample_encoding,
  input  logic [5:0] valid_bit_count,
  output logic       job_valid,
  output job_t       job
);

  logic [7:0]  pos;
  logic [31:0] assembled;
  logic [2:0]  nbytes;
  logic [5:0]  cbits;
  logic        cfg_ok;
  logic [8:0]  frame_size;
  logic [7:0]  start;
  logic [8:0]  rel;
  logic [31:0] merged;
  logic        frame_done;

  // Configuration decode
  always_comb begin
    unique case (enc_t'(sample_encoding))
      ENC_PCM16: nbytes = 3'd2;
      ENC_PCM24: nbytes = 3'd3;
      default:   nbytes = 3'd4;
    endcase
    cbits      = {nbytes, 3'b000};
    frame_size = 9'(channel_count) * 9'(nbytes);
    start      = 8'(selected_channel) * 8'(nbytes);
    cfg_ok = (channel_count != 6'd0) && ({26'd0, channel_count} <= 32'(MAX_CHANNELS))
           && ({1'b0, selected_channel} < channel_count)
           && ((enc_t'(sample_encoding) == ENC_FLOAT32)
               || ((valid_bit_count != 6'd0) && (valid_bit_count <= cbits)));
  end

  // Byte merge and frame close detection
  always_comb begin
    rel    = {1'b0, pos} - {1'b0, start};
    merged = assembled;
    if ((pos >= start) && (rel < {6'd0, nbytes}))
      merged = assembled | ({24'd0, in_item.stream_byte} << {rel[1:0], 3'b000});
    frame_done = ({1'b0, pos} + 9'd1 >= frame_size);
    job.raw      = merged;
    job.is_float = (enc_t'(sample_encoding) == ENC_FLOAT32);
    job.cbits    = cbits;
    job.vbits    = valid_bit_count;
    job.last     = in_item.buffer_end;
    job_valid    = 1'b0;
    job.status   = ST_OK;
    if (!cfg_ok) begin
      job_valid  = in_item.buffer_end;
      job.status = ST_BADCFG;
    end else if (frame_done) begin
      job_valid = 1'b1;
    end else if (in_item.buffer_end) begin
      job_valid  = 1'b1;
      job.status = ST_PARTIAL;
    end
    job_valid = job_valid & in_valid;
  end

  // Position and assembly registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 8'd0;
      assembled <= 32'd0;
    end else if (take) begin
      if (!cfg_ok) begin
        if (in_item.buffer_end) begin
          pos       <= 8'd0;
          assembled <= 32'd0;
        end
      end else if (frame_done || in_item.buffer_end) begin
        pos       <= 8'd0;
        assembled <= 32'd0;
      end else begin
        pos       <= pos + 8'd1;
        assembled <= merged;
      end
    end
  end

endmodule

FILE: rtl/pcx_queue.sv
// Two-entry queue between front end and converter.
module pcx_queue
  import pcx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_data,
  output logic full,
  output logic rd_valid,
  output job_t rd_data,
  input  logic rd
);

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

FILE: rtl/pcx_convert.sv
// Back end: two-stage PCM to float32 conversion with output register.
module pcx_convert
  import pcx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic        s1_valid, s2_valid;
  logic        adv2, adv1;
  // Stage 1 registers
  logic [31:0] s1_mag;
  logic        s1_sign, s1_float, s1_last;
  logic [1:0]  s1_status;
  logic [31:0] s1_raw;
  logic [5:0]  s1_vbits;

  // Stage 0 combinational: sign extend, truncating shift, magnitude
  logic signed [32:0] sv;
  logic [5:0]  shamt;
  logic [31:0] mag0;
  always_comb begin
    unique case (job.cbits)
      6'd16:   sv = 33'(signed'(job.raw[15:0]));
      6'd24:   sv = 33'(signed'(job.raw[23:0]));
      default: sv = 33'(signed'(job.raw[31:0]));
    endcase
    shamt = job.cbits - job.vbits;
    // Magnitude shift truncates toward zero
    if (sv < 0) mag0 = 32'((-sv) >> shamt[4:0]);
    else        mag0 = 32'(sv >> shamt[4:0]);
  end

  // Stage 1 combinational: normalize and round
  logic [4:0]  p;
  logic [31:0] norm;
  logic [23:0] q;
  logic [24:0] qr;
  logic        guard, sticky;
  logic [22:0] mant;
  logic [8:0]  expo;
  logic [31:0] fbits;
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) if (s1_mag[i]) p = 5'(i);
    norm   = s1_mag << (5'd31 - p);
    q      = norm[31:8];
    guard  = norm[7];
    sticky = |norm[6:0];
    qr     = {1'b0, q} + {24'd0, guard & (sticky | q[0])};
    expo   = {4'd0, p} + 9'd128 - {3'd0, s1_vbits};
    if (qr[24]) begin
      mant = qr[23:1];
      expo = expo + 9'd1;
    end else begin
      mant = qr[22:0];
    end
    if (s1_float)           fbits = s1_raw;
    else if (s1_mag == '0)  fbits = 32'd0;
    else                    fbits = {s1_sign, expo[7:0], mant};
  end

  assign adv2      = !s2_valid || out_ready;
  assign adv1      = !s1_valid || adv2;
  assign job_ready = adv1;
  assign out_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= job_valid;
      if (adv2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_mag    <= (job.status == ST_OK) ? mag0 : 32'd0;
      s1_sign   <= sv < 0;
      s1_float  <= job.is_float && (job.status == ST_OK);
      s1_raw    <= job.raw;
      s1_vbits  <= job.vbits;
      s1_last   <= job.last;
      s1_status <= job.status;
    end
    if (adv2 && s1_valid) begin
      out_item.sample_bits <= fbits;
      out_item.status      <= s1_status;
      out_item.last_sample <= s1_last;
    end
  end

endmodule

FILE: rtl/pcm_channel_extract_to_float_top.sv
// Top level of the interleaved PCM channel extractor to float32.
// Takes one stream byte per cycle with no bubbles while the output side keeps up;
// after the frame's final byte, a sample passes through the front queue slot,
// convert stage and output register. Only the byte that closes a frame, or a byte
// marked as buffer end, produces a result; all other bytes produce none.
// Configuration may only change while no request is in flight.
`include "pcm_channel_extract_to_float_top_defines.svh"
module pcm_channel_extract_to_float_top
  import pcx_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  logic [5:0] channel_count;
  logic [4:0] selected_channel;
  logic [1:0] sample_encoding;
  logic [5:0] valid_bit_count;
  logic       job_valid, q_full, q_valid, conv_ready, take;
  job_t       job, q_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= 6'd2;
      selected_channel <= 5'd0;
      sample_encoding  <= ENC_PCM16;
      valid_bit_count  <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT:    channel_count    <= cfg_data;
        REG_SELECTED_CHANNEL: selected_channel <= cfg_data[4:0];
        REG_SAMPLE_ENCODING:  sample_encoding  <= cfg_data[1:0];
        REG_VALID_BIT_COUNT:  valid_bit_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  pcx_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst, .in_valid, .in_item(in_data), .take,
    .channel_count, .selected_channel, .sample_encoding, .valid_bit_count,
    .job_valid, .job
  );

  pcx_queue u_queue (
    .clk, .rst, .wr(take && job_valid), .wr_data(job), .full(q_full),
    .rd_valid(q_valid), .rd_data(q_job), .rd(q_valid && conv_ready)
  );

  pcx_convert u_conv (
    .clk, .rst, .job_valid(q_valid), .job(q_job), .job_ready(conv_ready),
    .out_valid, .out_ready, .out_item(out_data)
  );

  `PCX_ASSERT_IMPL(a_no_overflow, q_full, !take, "queue written while full")
  `PCX_ASSERT_IMPL(a_bad_is_zero, out_valid && (out_data.status != ST_OK),
    (out_data.sample_bits == 32'd0) && out_data.last_sample, "error result not zero/last")
  `PCX_ASSERT_NEXT(a_take_posted, take && job_valid && !q_full, q_valid,
    "accepted job missing from queue")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the interleaved PCM channel extractor to float32.
module tb_top
  import pcx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CH      = 32;
  localparam int NUM_RANDOM  = 1950;
  localparam int SETTLE_CYC  = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_CHANNEL_COUNT;
  logic [5:0] cfg_data = '0;

  pcm_channel_extract_to_float_top #(.MAX_CHANNELS(MAX_CH)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow registers and frame state of the extractor
  logic [5:0]  num_channels = 6'd2;
  logic [4:0]  pick_channel = 5'd0;
  enc_t        encoding     = ENC_PCM16;
  logic [5:0]  valid_bits   = 6'd16;
  logic [7:0]  byte_pos     = '0;
  logic [31:0] gathered     = '0;

  out_item_t   pending_samples[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          samples_seen = 0;
  int          partial_seen = 0;
  int          badcfg_seen = 0;
  bit          rx_no_stall = 1'b0;
  bit          tx_no_gap = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int container_bytes(input enc_t e);
    case (e)
      ENC_PCM16: return 2;
      ENC_PCM24: return 3;
      default:   return 4;
    endcase
  endfunction

  function automatic bit config_valid();
    int cb;
    cb = container_bytes(encoding) * 8;
    if (num_channels == 0 || num_channels > MAX_CH) return 1'b0;
    if (pick_channel >= num_channels) return 1'b0;
    if (encoding != ENC_FLOAT32 && (valid_bits == 0 || valid_bits > cb)) return 1'b0;
    return 1'b1;
  endfunction

  // Integer sample to float32: truncating divide, round half to even, scale
  function automatic logic [31:0] pcm_as_float(input logic [31:0] raw, input int cbits,
                                               input int vbits);
    longint unsigned cmask, sbit, x, m, q, rem, half;
    longint          v;
    int              shift, p, drop, expo;
    bit              neg;
    logic [22:0]     mant;
    cmask = (cbits >= 32) ? 64'hFFFF_FFFF : ((64'd1 << cbits) - 1);
    sbit  = 64'd1 << (cbits - 1);
    x     = ({32'd0, raw} & cmask) ^ sbit;
    v     = longint'(x) - longint'(sbit);
    shift = cbits - vbits;
    if (shift != 0) v = v / (longint'(1) << shift);
    if (v == 0) return 32'd0;
    neg = (v < 0);
    m   = neg ? longint'(-v) : v;
    p   = 0;
    while (p < 63 && (m >> (p + 1)) != 0) p++;
    if (p > 23) begin
      drop = p - 23;
      q    = m >> drop;
      rem  = m & ((64'd1 << drop) - 1);
      half = 64'd1 << (drop - 1);
      if (rem > half || (rem == half && q[0])) q++;
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        p++;
      end
      mant = q[22:0];
    end else begin
      mant = 23'(m << (23 - p));
    end
    expo = p + 128 - vbits;
    return {neg, 8'(expo), mant};
  endfunction

  // Advance the frame state by one byte; returns 1 when a sample comes out
  function automatic bit frame_step(input logic [7:0] b, input bit e, output out_item_t r);
    int nb, fsize, first, pos;
    r = '0;
    if (!config_valid()) begin
      if (!e) return 1'b0;
      byte_pos = '0;
      gathered = '0;
      r.status = ST_BADCFG;
      r.last_sample = 1'b1;
      return 1'b1;
    end
    nb    = container_bytes(encoding);
    fsize = num_channels * nb;
    first = pick_channel * nb;
    pos   = byte_pos;
    if (pos >= first && pos < first + nb) gathered |= 32'(b) << (8 * (pos - first));
    if (pos + 1 >= fsize) begin
      r.sample_bits = (encoding == ENC_FLOAT32) ? gathered
                                                 : pcm_as_float(gathered, nb * 8, valid_bits);
      r.status      = ST_OK;
      r.last_sample = e;
      byte_pos = '0;
      gathered = '0;
      return 1'b1;
    end
    if (e) begin
      r.status = ST_PARTIAL;
      r.last_sample = 1'b1;
      byte_pos = '0;
      gathered = '0;
      return 1'b1;
    end
    byte_pos = 8'(pos + 1);
    return 1'b0;
  endfunction

  // Send one request; valid stays up into the next request when there is no gap
  task automatic send_byte(input logic [7:0] b, input bit e, output bit got,
                           output out_item_t r);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: b, buffer_end: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = frame_step(b, e, r);
    if (got) pending_samples.push_back(r);
    bytes_sent++;
  endtask

  // Wait until the block is idle: all samples back and pipeline settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] cc, input logic [4:0] sel, input enc_t enc,
                            input logic [5:0] vb);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;    cfg_data <= cc;            @(posedge clk);
    cfg_index <= REG_SELECTED_CHANNEL; cfg_data <= 6'(sel);       @(posedge clk);
    cfg_index <= REG_SAMPLE_ENCODING;  cfg_data <= 6'(enc);       @(posedge clk);
    cfg_index <= REG_VALID_BIT_COUNT;  cfg_data <= vb;            @(posedge clk);
    cfg_we <= 1'b0;
    num_channels = cc;
    pick_channel = sel;
    encoding     = enc;
    valid_bits   = vb;
  endtask

  // Result checker with random receiver stalls
  int rx_hold = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        out_item_t want;
        if (pending_samples.size() == 0) begin
          report($sformatf("unexpected sample %h", out_data));
        end else begin
          want = pending_samples.pop_front();
          if (out_data.sample_bits !== want.sample_bits)
            report($sformatf("sample_bits %h, want %h", out_data.sample_bits,
                             want.sample_bits));
          if (out_data.status !== want.status)
            report($sformatf("status %0d, want %0d", out_data.status, want.status));
          if (out_data.last_sample !== want.last_sample)
            report($sformatf("last_sample %0b, want %0b", out_data.last_sample,
                             want.last_sample));
        end
        samples_seen++;
        if (out_data.status == ST_PARTIAL) partial_seen++;
        if (out_data.status == ST_BADCFG) badcfg_seen++;
        rx_hold = rx_no_stall ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Directed table: config rows or byte rows, some with a typed expectation
  typedef struct {
    bit          is_cfg;
    logic [5:0]  cc;
    logic [4:0]  sel;
    enc_t        enc;
    logic [5:0]  vb;
    logic [7:0]  b;
    bit          e;
    bit          chk;
    logic [31:0] bits;
    status_t     st;
    bit          last;
  } row_t;
  row_t directed[$];

  function automatic void add_cfg(input int cc, input int sel, input enc_t enc, input int vb);
    directed.push_back('{1'b1, 6'(cc), 5'(sel), enc, 6'(vb), 8'd0, 1'b0, 1'b0, 32'd0,
                         ST_OK, 1'b0});
  endfunction

  function automatic void add_byte(input int b, input bit e, input bit chk = 1'b0,
                                   input logic [31:0] bits = 0, input status_t st = ST_OK,
                                   input bit last = 1'b0);
    directed.push_back('{1'b0, 6'd0, 5'd0, ENC_FLOAT32, 6'd0, 8'(b), e, chk, bits, st, last});
  endfunction

  function automatic void build_table();
    // reset setup: two pcm16 channels, channel 0; full-scale negative
    add_byte('h00, 0); add_byte('h80, 0); add_byte('h11, 0);
    add_byte('h22, 0, 1, 32'hBF80_0000, ST_OK, 0);
    // largest positive, buffer end on the byte that closes the frame
    add_byte('hFF, 0); add_byte('h7F, 0); add_byte('h00, 0); add_byte('h00, 1);
    // partial frame at buffer end
    add_byte('h12, 1, 1, 32'd0, ST_PARTIAL, 1);
    // zero sample
    add_byte('h00, 0); add_byte('h00, 0); add_byte('h00, 0);
    add_byte('h00, 0, 1, 32'd0, ST_OK, 0);
    // float32 passes through
    add_cfg(1, 0, ENC_FLOAT32, 0);
    add_byte('h78, 0); add_byte('h56, 0); add_byte('h34, 0);
    add_byte('h12, 1, 1, 32'h1234_5678, ST_OK, 1);
    // invalid configuration: zero channels
    add_cfg(0, 0, ENC_PCM16, 16);
    add_byte('hAA, 0);
    add_byte('hBB, 1, 1, 32'd0, ST_BADCFG, 1);
    // pcm32 full width, most negative
    add_cfg(1, 0, ENC_PCM32, 32);
    add_byte('h00, 0); add_byte('h00, 0); add_byte('h00, 0);
    add_byte('h80, 0, 1, 32'hBF80_0000, ST_OK, 0);
    // register change mid-frame leaves position beyond the new frame
    add_cfg(2, 1, ENC_PCM16, 16);
    add_byte('h55, 0); add_byte('h66, 0);
    add_cfg(1, 0, ENC_PCM16, 1);
    add_byte('hFF, 0);
    // pcm24 with one valid bit
    add_cfg(1, 0, ENC_PCM24, 1);
    add_byte('hFF, 0); add_byte('hFF, 0); add_byte('hFF, 0);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random configuration: mostly valid, small frames, with extremes and bad settings
  task automatic random_config();
    logic [5:0] cc, vb;
    logic [4:0] sel;
    enc_t       enc;
    int         cb;
    enc = enc_t'($urandom_range(0, 3));
    cb  = container_bytes(enc) * 8;
    case ($urandom_range(0, 9))
      0:       cc = 6'd32;
      1:       cc = 6'd1;
      default: cc = 6'($urandom_range(1, 4));
    endcase
    sel = 5'($urandom_range(0, cc - 1));
    case ($urandom_range(0, 5))
      0:       vb = 6'(cb);
      1:       vb = 6'd1;
      default: vb = 6'($urandom_range(1, cb));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: cc = 6'd0;
        1: cc = 6'($urandom_range(33, 63));
        2: sel = 5'($urandom_range(cc, 31));
        default: begin
          enc = enc_t'($urandom_range(1, 3));
          vb = ($urandom_range(0, 1) != 0) ? 6'd0
                : 6'($urandom_range(container_bytes(enc) * 8 + 1, 63));
        end
      endcase
    end
    set_config(cc, sel, enc, vb);
  endtask

  initial begin
    bit        got;
    out_item_t r;
    int        fsize, frames, nb;
    build_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_config(directed[i].cc, directed[i].sel, directed[i].enc, directed[i].vb);
      end else begin
        send_byte(directed[i].b, directed[i].e, got, r);
        if (directed[i].chk &&
            (!got || r.sample_bits !== directed[i].bits || r.status !== directed[i].st ||
             r.last_sample !== directed[i].last))
          report($sformatf("directed row %0d predicted %h", i, r));
      end
    end

    // Random phases: well-formed buffers with random content, plus noise
    while (bytes_sent < NUM_RANDOM + directed.size()) begin
      random_config();
      tx_no_gap   = ($urandom_range(0, 4) == 0);
      rx_no_stall = ($urandom_range(0, 4) == 0);
      if (!config_valid() || $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(4, 20)) send_byte(pick_byte(), $urandom_range(0, 5) == 0, got, r);
      end else begin
        nb     = container_bytes(encoding);
        fsize  = num_channels * nb;
        frames = (fsize > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
        for (int f = 0; f < frames; f++) begin
          for (int k = 0; k < fsize; k++) begin
            bit last_byte;
            last_byte = (f == frames - 1) && (k == fsize - 1) && ($urandom_range(0, 1) != 0);
            // an occasional early buffer end breaks the frame
            if (!last_byte && $urandom_range(0, 60) == 0) last_byte = 1'b1;
            send_byte(pick_byte(), last_byte, got, r);
          end
        end
      end
    end

    drain();
    $display("Sent %0d bytes, checked %0d samples (%0d partial, %0d bad config).",
             bytes_sent, samples_seen, partial_seen, badcfg_seen);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout with %0d samples outstanding", pending_samples.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
